### sv/fba_pkg.sv
// Shared types and constants for the fit block allocator.
// No dependencies; imported by fba_pick_unit and fit_block_allocator_top.
package fba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int SIZE_BITS    = 16;
   localparam int IDX_BITS     = 6;
   localparam int INDEX_LIMIT  = 1 << IDX_BITS;
   localparam int ADDR_BITS    = $clog2(MAX_BLOCKS);
   localparam int SEARCH_LIMIT = (MAX_BLOCKS < INDEX_LIMIT) ? MAX_BLOCKS : INDEX_LIMIT;
   localparam int CNT_BITS     = $clog2(SEARCH_LIMIT + 1);
   localparam int MODE_BITS    = 2;
   localparam int COUNT_BITS   = 7;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 7;

   // placement policies; the unused code behaves as first fit
   localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_FIT_MODE    = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [IDX_BITS-1:0]  block_index;
      logic [SIZE_BITS-1:0] size;
   } req_type;

   typedef struct packed {
      logic                 granted;
      logic [IDX_BITS-1:0]  chosen_block;
      logic [SIZE_BITS-1:0] remaining_size;
   } rsp_type;

   // control from the sequencer to the pick unit
   typedef struct packed {
      logic                 clear;
      logic                 sample;
      logic [MODE_BITS-1:0] mode;
   } pick_ctl_type;

endpackage

### sv/fit_block_allocator_top.sv
// Fit block allocator top level: free-size table, scan sequencer, result register.
// Depends on fba_pkg and fba_pick_unit.
//
// Usage:
//  - req channel (req_valid/req_stall/req_payload) takes one request at a time.
//    A load (command 0) writes one block's free size; an allocate (command 1)
//    searches blocks 0..min(block_count, 64)-1 for one whose free size covers the size.
//  - rsp channel returns exactly one result per request: granted, block and
//    the size left in that block (all zero when nothing fits).
//  - csr port writes fit_mode (0 first, 1 best, 2 worst fit) and block_count;
//    write only while no request is in flight.
// Timing:
//  - load: the table write and the result register both take effect on acceptance.
//  - allocate: the scan reads n = min(block_count, 64) entries, one table entry
//    per cycle through the registered RAM read port and one shared compare unit,
//    then a write-back state if granted; with n = 0 no entry is read.
//  - req_stall is high from acceptance until the result enters the output
//    register, so requests run one at a time.
// Reset (synchronous, active high) clears control state, fit_mode to first
// fit and block_count to 1; table entries are undefined until loaded.
// A stalled result holds in the output register; the next request is taken
// only after that result leaves the sequencer.
module fit_block_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fba_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fba_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic [fba_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fba_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import fba_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_BITS-1:0]  fit_mode_ff, fit_mode_in;
   logic [COUNT_BITS-1:0] block_count_ff, block_count_in;

   logic [SIZE_BITS-1:0] req_size_ff, req_size_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic [CNT_BITS-1:0]  limit_now;
   logic                 rd_valid_ff, rd_valid_in;
   logic [ADDR_BITS-1:0] rd_idx_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 issue;

   rsp_type res_ff, res_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // free-size table
   logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;

   pick_ctl_type         pick_ctl;
   logic                 found;
   logic [ADDR_BITS-1:0] pick_idx;
   logic [SIZE_BITS-1:0] size_left;

   logic req_accept, load_ok, rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_ok    = int'(req_payload.block_index) < MAX_BLOCKS;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // saturate the search length to the table and index range
   assign limit_now = (int'(block_count_ff) > SEARCH_LIMIT) ? CNT_BITS'(SEARCH_LIMIT)
                                                           : CNT_BITS'(block_count_ff);
   assign issue = (state_ff == ST_SCAN) && (cnt_ff < limit_ff);

   // configuration registers
   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FIT_MODE:    fit_mode_in    = csr_wdata[MODE_BITS-1:0];
            REG_BLOCK_COUNT: block_count_in = csr_wdata[COUNT_BITS-1:0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_size_in = req_size_ff;
      cnt_in      = cnt_ff;
      limit_in    = limit_ff;
      rd_valid_in = issue;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = pick_idx;
      mem_wdata   = size_left;
      pick_ctl.clear  = 1'b0;
      pick_ctl.sample = rd_valid_ff;
      pick_ctl.mode   = fit_mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_size_in = req_payload.size;
               res_in      = '0;
               if (req_payload.command == CMD_LOAD) begin
                  if (load_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_BITS'(req_payload.block_index);
                     mem_wdata = req_payload.size;
                     res_in    = '{granted: 1'b1,
                                   chosen_block: req_payload.block_index,
                                   remaining_size: req_payload.size};
                  end
                  state_in = ST_DONE;
               end else begin
                  pick_ctl.clear = 1'b1;
                  cnt_in   = '0;
                  limit_in = limit_now;
                  state_in = (limit_now == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            // last read has been compared once its valid has drained
            if (cnt_ff == limit_ff && !rd_valid_ff) begin
               state_in = found ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            res_in   = '{granted: 1'b1,
                         chosen_block: IDX_BITS'(pick_idx),
                         remaining_size: size_left};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= FIT_FIRST;
         block_count_ff <= COUNT_BITS'(1);
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_size_ff <= req_size_in;
      cnt_ff      <= cnt_in;
      limit_ff    <= limit_in;
      rd_idx_ff   <= cnt_ff[ADDR_BITS-1:0];
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // table RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cnt_ff[ADDR_BITS-1:0]];
   end

   fba_pick_unit u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .req_size   (req_size_ff),
      .entry_size (rd_data_ff),
      .entry_idx  (rd_idx_ff),
      .found      (found),
      .pick_idx   (pick_idx),
      .size_left  (size_left)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_nogrant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.granted
         |-> rsp_payload.chosen_block == '0 && rsp_payload.remaining_size == '0)
      else $error("ungranted result carries nonzero fields");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= limit_ff)
      else $error("scan counter ran past the search limit");

   a_write_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> found)
      else $error("write-back without a candidate");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after accepting a request");
`endif

endmodule

### sv/fba_pick_unit.sv
// Shared compare/select unit: keeps the running candidate of one scan.
// Depends on fba_pkg.
module fba_pick_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  fba_pkg::pick_ctl_type         ctl,
   input  logic [fba_pkg::SIZE_BITS-1:0] req_size,
   input  logic [fba_pkg::SIZE_BITS-1:0] entry_size,
   input  logic [fba_pkg::ADDR_BITS-1:0] entry_idx,
   output logic                          found,
   output logic [fba_pkg::ADDR_BITS-1:0] pick_idx,
   output logic [fba_pkg::SIZE_BITS-1:0] size_left
);
   import fba_pkg::*;

   logic                 found_ff, found_in;
   logic [ADDR_BITS-1:0] pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_size_ff, pick_size_in;
   logic                 fits, better;

   always_comb begin
      fits   = entry_size >= req_size;
      better = !found_ff
            || (ctl.mode == FIT_BEST  && entry_size < pick_size_ff)
            || (ctl.mode == FIT_WORST && entry_size > pick_size_ff);
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && fits && better) begin
         found_in     = 1'b1;
         pick_in      = entry_idx;
         pick_size_in = entry_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
   end

   assign found     = found_ff;
   assign pick_idx  = pick_ff;
   assign size_left = pick_size_ff - req_size;

endmodule
